FILE: design/u2l_pkg.sv
// ----------------------------------------------------------------------------
// u2l_pkg
// Shared types, codes and lead byte decoding for the UTF-8 to Latin-1 decoder.
// ----------------------------------------------------------------------------
package u2l_pkg;

    localparam logic [7:0] CHAR_UNREP = 8'h3F;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam int         ACC_WIDTH  = 31;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_STOP = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]  out_char;
        t_kind       kind;
        logic [15:0] char_count;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_push;

    typedef struct packed {
        logic [2:0] rem;
        logic [6:0] mask;
    } t_lead;

    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead l;
        if (b[7] == 1'b0) begin
            l = '{rem: 3'd0, mask: 7'h7F};
        end else if (b[6] == 1'b0) begin
            l = '{rem: 3'd4, mask: 7'h3F};
        end else if (b[5] == 1'b0) begin
            l = '{rem: 3'd1, mask: 7'h1F};
        end else if (b[4] == 1'b0) begin
            l = '{rem: 3'd2, mask: 7'h0F};
        end else if (b[3] == 1'b0) begin
            l = '{rem: 3'd3, mask: 7'h07};
        end else if (b[2] == 1'b0) begin
            l = '{rem: 3'd4, mask: 7'h03};
        end else begin
            l = '{rem: 3'd5, mask: 7'h01};
        end
        return l;
    endfunction

    function automatic logic [7:0] to_latin1(input logic [ACC_WIDTH-1:0] v);
        return (v[ACC_WIDTH-1:8] == '0) ? v[7:0] : CHAR_UNREP;
    endfunction

endpackage

FILE: design/u2l_in_if.sv
// ----------------------------------------------------------------------------
// u2l_in_if
// Byte stream channel: valid, ready and one UTF-8 byte.
// ----------------------------------------------------------------------------
interface u2l_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: design/u2l_out_if.sv
// ----------------------------------------------------------------------------
// u2l_out_if
// Result channel: valid, ready and one decoded result.
// ----------------------------------------------------------------------------
interface u2l_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic [1:0]  kind;
    logic [15:0] char_count;
    logic        last_of_run;

    modport source (output valid, output out_char, output kind, output char_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input kind, input char_count,
                    input last_of_run, output ready);
endinterface

FILE: design/utf8_to_latin1_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_latin1_decoder_core
// UTF-8 byte stream to Latin-1 character decoder with output capacity limit.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while input ready is high and decodes it in a single
// pass against the open sequence state; its results land in a four-entry
// result queue in the cycle after the transfer. Most bytes give at most one
// result, so the block sustains one byte per clock while the result side keeps
// up. A byte that cuts a sequence short can give two results, which drain one
// per cycle when taken; input ready drops whenever fewer than two entries are free.
// ----------------------------------------------------------------------------
module utf8_to_latin1_decoder_core
    import u2l_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    u2l_in_if.sink      i_byte_ch,
    u2l_out_if.source   o_char_ch
);

    logic [15:0] r_capacity;
    logic        room2;
    logic        take;
    t_push       push;

    assign i_byte_ch.ready = room2;
    assign take            = i_byte_ch.valid && room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    u2l_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_valid    (take),
        .i_byte     (i_byte_ch.in_byte),
        .o_push     (push)
    );

    u2l_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_res   (o_char_ch)
    );

endmodule

FILE: design/u2l_step.sv
// ----------------------------------------------------------------------------
// u2l_step
// Decode state and per-byte logic; produces zero, one or two results per byte.
// ----------------------------------------------------------------------------
module u2l_step
    import u2l_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_capacity,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    output t_push       o_push
);

    localparam int CW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [ACC_WIDTH-1:0]   r_acc, n_acc;
    logic [2:0]             r_rem, n_rem;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_halted, n_halted;

    function automatic logic is_full(input logic [COUNT_WIDTH-1:0] c,
                                     input logic [15:0] cap);
        logic [CW-1:0] ce;
        logic [CW-1:0] ke;
        ce = CW'(c);
        ke = CW'(cap);
        return (cap != 16'd0) && (ce >= ke);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [15:0] shown(input logic [COUNT_WIDTH-1:0] c);
        logic [CW-1:0] ce;
        ce = CW'(c);
        return (ce > CW'(16'hFFFF)) ? 16'hFFFF : ce[15:0];
    endfunction

    function automatic t_result make_res(input logic [7:0] ch, input t_kind k,
                                         input logic [15:0] cnt);
        t_result r;
        r.out_char    = ch;
        r.kind        = k;
        r.char_count  = cnt;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic [COUNT_WIDTH-1:0] cur;
        logic [ACC_WIDTH-1:0]   acc_sh;
        logic                   live;
        t_lead                  lead;
        t_result                res;

        n_acc    = r_acc;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_halted = r_halted;
        o_push   = '0;
        cur      = r_cnt;
        live     = 1'b1;
        acc_sh   = {r_acc[ACC_WIDTH-7:0], i_byte[5:0]};
        lead     = lead_decode(i_byte);
        res      = '0;

        if (i_valid) begin
            if (r_halted) begin
                if (i_byte == 8'd0) begin
                    n_acc    = '0;
                    n_rem    = '0;
                    n_cnt    = '0;
                    n_halted = 1'b0;
                end
            end else begin
                if (r_rem != 3'd0) begin
                    if (i_byte != 8'd0 && i_byte[7:6] == 2'b10) begin
                        live  = 1'b0;
                        n_rem = r_rem - 3'd1;
                        n_acc = acc_sh;
                        if (r_rem == 3'd1) begin
                            n_acc = '0;
                            if (is_full(cur, i_capacity)) begin
                                res      = make_res(CHAR_NUL, KIND_STOP, shown(cur));
                                n_halted = 1'b1;
                            end else begin
                                cur = sat_inc(cur);
                                res = make_res(to_latin1(acc_sh), KIND_CHAR, shown(cur));
                            end
                            o_push.res0  = res;
                            o_push.count = 2'd1;
                        end
                    end else begin
                        n_acc = '0;
                        n_rem = '0;
                        if (is_full(cur, i_capacity)) begin
                            res      = make_res(CHAR_NUL, KIND_STOP, shown(cur));
                            n_halted = 1'b1;
                            live     = 1'b0;
                        end else begin
                            cur = sat_inc(cur);
                            res = make_res(to_latin1(r_acc), KIND_CHAR, shown(cur));
                        end
                        o_push.res0  = res;
                        o_push.count = 2'd1;
                    end
                end
                n_cnt = cur;

                if (!live && n_halted && i_byte == 8'd0) begin
                    n_cnt    = '0;
                    n_halted = 1'b0;
                end

                if (live) begin
                    if (i_byte == 8'd0) begin
                        res = make_res(CHAR_NUL,
                                       is_full(cur, i_capacity) ? KIND_STOP : KIND_END,
                                       shown(cur));
                        n_acc    = '0;
                        n_rem    = '0;
                        n_cnt    = '0;
                        n_halted = 1'b0;
                        if (o_push.count == 2'd0) begin
                            o_push.res0 = res;
                        end else begin
                            o_push.res1 = res;
                        end
                        o_push.count = o_push.count + 2'd1;
                    end else begin
                        n_acc = ACC_WIDTH'(i_byte & {1'b0, lead.mask});
                        n_rem = lead.rem;
                        if (lead.rem == 3'd0) begin
                            n_acc = '0;
                            if (is_full(cur, i_capacity)) begin
                                res      = make_res(CHAR_NUL, KIND_STOP, shown(cur));
                                n_halted = 1'b1;
                            end else begin
                                cur = sat_inc(cur);
                                res = make_res({1'b0, i_byte[6:0]}, KIND_CHAR, shown(cur));
                            end
                            n_cnt = cur;
                            if (o_push.count == 2'd0) begin
                                o_push.res0 = res;
                            end else begin
                                o_push.res1 = res;
                            end
                            o_push.count = o_push.count + 2'd1;
                        end
                    end
                end
            end
        end

        if (o_push.count == 2'd1) begin
            o_push.res0.last_of_run = 1'b1;
        end
        if (o_push.count == 2'd2) begin
            o_push.res1.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_halted <= n_halted;
        end
    end

endmodule

FILE: design/u2l_out_fifo.sv
// ----------------------------------------------------------------------------
// u2l_out_fifo
// Four-entry result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module u2l_out_fifo
    import u2l_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_push    i_push,
    output logic     o_room2,
    u2l_out_if.source o_res
);

    t_result    r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_count, n_count;
    logic       pop;
    t_result    head;

    assign head          = r_mem[r_rp];
    assign o_res.valid   = (r_count != 3'd0);
    assign o_res.out_char    = head.out_char;
    assign o_res.kind        = head.kind;
    assign o_res.char_count  = head.char_count;
    assign o_res.last_of_run = head.last_of_run;
    assign o_room2       = (r_count <= 3'd2);

    assign pop     = o_res.valid && o_res.ready;
    assign n_wp    = r_wp + i_push.count;
    assign n_rp    = r_rp + 2'(pop);
    assign n_count = r_count + 3'(i_push.count) - 3'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule
